@@ hdl/prqs_pkg.sv @@
package prqs_pkg;

    localparam int NUM_TASKS  = 16;
    localparam int NUM_LEVELS = 8;
    localparam int TASK_W     = $clog2(NUM_TASKS);
    localparam int LEVEL_W    = $clog2(NUM_LEVELS);

    typedef enum logic [2:0] {
        ACT_ENQUEUE   = 3'd0,
        ACT_UNLINK    = 3'd1,
        ACT_REPRIO    = 3'd2,
        ACT_DEQUEUE   = 3'd3,
        ACT_DEQ_MIN   = 3'd4,
        ACT_PEEK      = 3'd5,
        ACT_SCHEDULE  = 3'd6,
        ACT_SWITCH    = 3'd7
    } action_t;

    typedef struct packed {
        logic [2:0] action;
        logic [3:0] task_id;
        logic [2:0] prio;
        logic       higher_only;
        logic [7:0] isr_depth;
        logic       sched_locked;
    } req_t;

    typedef struct packed {
        logic       found;
        logic [3:0] out_task;
        logic [2:0] out_prio;
        logic       switch_now;
        logic       switch_deferred;
    } rsp_t;

    // controller -> datapath
    typedef struct packed {
        logic load;     // capture request
        logic decode;   // evaluate request, set up first list operation
        logic rem;      // perform removal
        logic app;      // perform append
        logic finish;   // commit current task, emit result
    } prqs_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic need_rem;
        logic need_app;
    } prqs_sts_t;

endpackage

@@ hdl/priority_ready_queue_scheduler.sv @@
// Ready queue scheduler: one FIFO of task ids per priority level.
// The result strobe is registered from the finish step (load, decode, remove,
// append, finish); busy is high from decode through finish, one action at a time.
// No new action is taken until the sequencer's fixed pass returns to idle.
// Reset: asynchronous, active low; clears level mask, task levels and queued
// flags, current task to task 0. The receiver cannot stall results.
module priority_ready_queue_scheduler (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    input  prqs_pkg::req_t   req,
    output logic             result_valid,
    output prqs_pkg::rsp_t   result
);
    import prqs_pkg::*;

    prqs_cmd_t cmd;
    prqs_sts_t sts;

    // sequencer: fixed pass, steps gated by datapath status
    prqs_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .cmd   (cmd),
        .sts   (sts)
    );

    // list stores, mask, priority encoder, result word
    prqs_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .cmd       (cmd),
        .sts       (sts),
        .rsp       (result),
        .rsp_valid (result_valid)
    );

endmodule

@@ hdl/prqs_ctrl.sv @@
module prqs_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    output prqs_pkg::prqs_cmd_t cmd,
    input  prqs_pkg::prqs_sts_t sts
);
    import prqs_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_DECODE = 5'b00010,
        S_REM    = 5'b00100,
        S_APP    = 5'b01000,
        S_FINISH = 5'b10000
    } state_t;

    state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                cmd.decode = 1'b1;
                state_next = S_REM;
            end
            S_REM:
            begin
                cmd.rem    = sts.need_rem;
                state_next = S_APP;
            end
            S_APP:
            begin
                cmd.app    = sts.need_app;
                state_next = S_FINISH;
            end
            S_FINISH:
            begin
                cmd.finish = 1'b1;
                state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    assign busy = (state_reg != S_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

@@ hdl/prqs_dp.sv @@
module prqs_dp (
    input  logic                clk,
    input  logic                rst_n,
    input  prqs_pkg::req_t      req,
    input  prqs_pkg::prqs_cmd_t cmd,
    output prqs_pkg::prqs_sts_t sts,
    output prqs_pkg::rsp_t      rsp,
    output logic                rsp_valid
);
    import prqs_pkg::*;

    logic [NUM_LEVELS-1:0] mask_reg;
    logic [TASK_W-1:0]     head_reg [NUM_LEVELS];
    logic [TASK_W-1:0]     tail_reg [NUM_LEVELS];
    logic [TASK_W-1:0]     next_reg [NUM_TASKS];
    logic [TASK_W-1:0]     prev_reg [NUM_TASKS];
    logic [LEVEL_W-1:0]    lvl_reg  [NUM_TASKS];
    logic [NUM_TASKS-1:0]  queued_reg;
    logic [TASK_W-1:0]     cur_reg;

    req_t               req_reg;
    logic               need_rem_reg, need_app_reg;
    logic [TASK_W-1:0]  rem_t_reg, app_t_reg, new_cur_reg;
    logic               set_cur_reg;
    logic [LEVEL_W-1:0] app_lvl_reg;
    rsp_t               res_reg;
    logic               rsp_valid_reg;

    // priority encode
    logic                top_any;
    logic [LEVEL_W-1:0]  top_lv;
    always_comb
    begin
        top_any = 1'b0;
        top_lv  = '0;
        for (int i = 0; i < NUM_LEVELS; i++)
        begin
            if (mask_reg[i])
            begin
                top_any = 1'b1;
                top_lv  = LEVEL_W'(i);
            end
        end
    end

    logic               tvalid;
    logic [TASK_W-1:0]  tid;
    logic [LEVEL_W-1:0] sat_prio;
    logic [LEVEL_W:0]   thr;
    assign tvalid   = ({28'd0, req_reg.task_id} < 32'(NUM_TASKS));
    assign tid      = TASK_W'(req_reg.task_id);
    assign sat_prio = ({29'd0, req_reg.prio} >= 32'(NUM_LEVELS)) ? LEVEL_W'(NUM_LEVELS - 1)
                                                                  : LEVEL_W'(req_reg.prio);
    assign thr      = {1'b0, lvl_reg[cur_reg]} + (LEVEL_W+1)'(req_reg.higher_only);

    // decode of the held request
    logic               dec_need_rem, dec_need_app, dec_set_cur, dec_lvl_we;
    logic [TASK_W-1:0]  dec_rem_t, dec_app_t, dec_new_cur;
    rsp_t               dec_res;
    always_comb
    begin
        dec_need_rem = 1'b0;
        dec_need_app = 1'b0;
        dec_set_cur  = 1'b0;
        dec_lvl_we   = 1'b0;
        dec_rem_t    = rem_t_reg;
        dec_app_t    = app_t_reg;
        dec_new_cur  = new_cur_reg;
        dec_res      = '0;
        case (action_t'(req_reg.action))
            ACT_ENQUEUE:
            begin
                if (tvalid && !queued_reg[tid])
                begin
                    dec_lvl_we   = 1'b1;
                    dec_app_t    = tid;
                    dec_need_app = 1'b1;
                end
            end
            ACT_UNLINK:
            begin
                if (tvalid && queued_reg[tid])
                begin
                    dec_rem_t    = tid;
                    dec_need_rem = 1'b1;
                end
            end
            ACT_REPRIO:
            begin
                if (tvalid && lvl_reg[tid] != sat_prio)
                begin
                    dec_rem_t    = tid;
                    dec_app_t    = tid;
                    dec_need_rem = queued_reg[tid];
                    dec_need_app = queued_reg[tid];
                    // idle task: level written now, queued one after removal
                    dec_lvl_we   = !queued_reg[tid];
                end
            end
            ACT_DEQUEUE, ACT_DEQ_MIN, ACT_PEEK:
            begin
                if (top_any && (req_reg.action != ACT_DEQ_MIN
                                || top_lv >= sat_prio
                                && {29'd0, req_reg.prio} < 32'(NUM_LEVELS)))
                begin
                    dec_res.found    = 1'b1;
                    dec_res.out_task = 4'(head_reg[top_lv]);
                    dec_res.out_prio = 3'(top_lv);
                    dec_rem_t        = head_reg[top_lv];
                    dec_need_rem     = (req_reg.action != ACT_PEEK);
                end
            end
            ACT_SCHEDULE:
            begin
                if (req_reg.isr_depth <= 8'd1 && !req_reg.sched_locked
                    && top_any && {1'b0, top_lv} >= thr)
                begin
                    dec_res.found           = 1'b1;
                    dec_res.out_task        = 4'(head_reg[top_lv]);
                    dec_res.out_prio        = 3'(top_lv);
                    dec_res.switch_now      = (req_reg.isr_depth == 8'd0);
                    dec_res.switch_deferred = (req_reg.isr_depth == 8'd1);
                    dec_rem_t               = head_reg[top_lv];
                    dec_need_rem            = 1'b1;
                    dec_app_t               = cur_reg;
                    // queued test is repeated after removal below
                    dec_need_app            = 1'b1;
                    dec_new_cur             = head_reg[top_lv];
                    dec_set_cur             = 1'b1;
                end
            end
            ACT_SWITCH:
            begin
                if (top_any)
                begin
                    dec_res.found      = 1'b1;
                    dec_res.out_task   = 4'(head_reg[top_lv]);
                    dec_res.out_prio   = 3'(top_lv);
                    dec_res.switch_now = 1'b1;
                    dec_rem_t          = head_reg[top_lv];
                    dec_need_rem       = 1'b1;
                    dec_new_cur        = head_reg[top_lv];
                    dec_set_cur        = 1'b1;
                end
            end
            default: ;
        endcase
    end

    // removal combinational views
    logic [LEVEL_W-1:0] rlv;
    logic [TASK_W-1:0]  rh, rt, rn, rp;
    assign rlv = lvl_reg[rem_t_reg];
    assign rh  = head_reg[rlv];
    assign rt  = tail_reg[rlv];
    assign rn  = next_reg[rem_t_reg];
    assign rp  = prev_reg[rem_t_reg];

    logic [TASK_W-1:0] atl;
    assign atl = tail_reg[app_lvl_reg];

    assign sts.need_rem = need_rem_reg;
    assign sts.need_app = need_app_reg;
    assign rsp          = res_reg;
    assign rsp_valid    = rsp_valid_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.load)
            req_reg <= req;
        if (cmd.rem)
        begin
            if (rh == rem_t_reg && rt == rem_t_reg)
                ;
            else if (rh == rem_t_reg)
                head_reg[rlv] <= rn;
            else if (rt == rem_t_reg)
                tail_reg[rlv] <= rp;
            else
            begin
                next_reg[rp] <= rn;
                prev_reg[rn] <= rp;
            end
        end
        if (cmd.app)
        begin
            if (mask_reg[app_lvl_reg])
            begin
                next_reg[atl]          <= app_t_reg;
                prev_reg[app_t_reg]    <= atl;
                tail_reg[app_lvl_reg]  <= app_t_reg;
            end
            else
            begin
                head_reg[app_lvl_reg] <= app_t_reg;
                tail_reg[app_lvl_reg] <= app_t_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask_reg      <= '0;
            queued_reg    <= '0;
            cur_reg       <= '0;
            for (int i = 0; i < NUM_TASKS; i++)
                lvl_reg[i] <= '0;
            need_rem_reg  <= 1'b0;
            need_app_reg  <= 1'b0;
            set_cur_reg   <= 1'b0;
            rsp_valid_reg <= 1'b0;
            rem_t_reg     <= '0;
            app_t_reg     <= '0;
            new_cur_reg   <= '0;
            app_lvl_reg   <= '0;
            res_reg       <= '0;
        end
        else
        begin
            rsp_valid_reg <= cmd.finish;
            if (cmd.decode)
            begin
                need_rem_reg <= dec_need_rem;
                need_app_reg <= dec_need_app;
                set_cur_reg  <= dec_set_cur;
                res_reg      <= dec_res;
                rem_t_reg    <= dec_rem_t;
                app_t_reg    <= dec_app_t;
                new_cur_reg  <= dec_new_cur;
                if (dec_lvl_we)
                    lvl_reg[tid] <= sat_prio;
                // no removal: append level from task level (enqueue sets it)
                app_lvl_reg <= (action_t'(req_reg.action) == ACT_ENQUEUE) ? sat_prio
                                                                          : lvl_reg[cur_reg];
            end
            if (cmd.rem)
            begin
                if (rh == rem_t_reg && rt == rem_t_reg)
                    mask_reg[rlv] <= 1'b0;
                queued_reg[rem_t_reg] <= 1'b0;
                if (action_t'(req_reg.action) == ACT_REPRIO)
                    lvl_reg[rem_t_reg] <= sat_prio;
                // schedule: current task appended only if not queued after pop
                if (action_t'(req_reg.action) == ACT_SCHEDULE)
                    need_app_reg <= !queued_reg[app_t_reg] || (app_t_reg == rem_t_reg);
                app_lvl_reg <= (action_t'(req_reg.action) == ACT_REPRIO) ? sat_prio
                                                                         : lvl_reg[app_t_reg];
            end
            if (cmd.app)
            begin
                mask_reg[app_lvl_reg]  <= 1'b1;
                queued_reg[app_t_reg]  <= 1'b1;
            end
            if (cmd.finish && set_cur_reg)
                cur_reg <= new_cur_reg;
        end
    end

endmodule
